// File: rtl/line_of_sight_angle_compose_assert.svh
`ifndef LINE_OF_SIGHT_ANGLE_COMPOSE_ASSERT_SVH
`define LINE_OF_SIGHT_ANGLE_COMPOSE_ASSERT_SVH
// check at every edge outside reset
`define LOSAC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// check at every edge, reset included
`define LOSAC_ASSERT_ALL(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// File: rtl/losac_pkg.sv
package losac_pkg;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int CORDIC_STAGES = 24;
	localparam int IN_W = 25;
	localparam int PITCH_W = 24;
	localparam int HEAD_W = 25;
	localparam int TURN_W = 32;
	localparam int TURN_SHIFT = 29 - ANGLE_FRAC_BITS;
	localparam int VW = 34;
	localparam int ZW = 34;
	localparam int AW = 37;
	localparam int PW = 2 * VW;
	localparam int SQ_W = 64;
	localparam int ROOT_W = SQ_W / 2;
	localparam int Q30_SH = 30;
	localparam int ROTS = 6;

	localparam logic signed [VW-1:0] CORDIC_INV_GAIN = VW'(32'h26DD3B6A);
	localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'h8000_0000);
	localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'h4000_0000);

	localparam int LAT_TURN = 4;
	localparam int LAT_SC = CORDIC_STAGES + 2;
	localparam int LAT_VEC = 2 * ROTS;
	localparam int LAT_SQ = 2;
	localparam int LAT_ISQ = ROOT_W;
	localparam int LAT_ATAN = CORDIC_STAGES + 1;
	localparam int LAT_OUT = 2;
	localparam int LAT_TOTAL = LAT_TURN + LAT_SC + LAT_VEC + LAT_SQ + LAT_ISQ + LAT_ATAN
		+ LAT_OUT;

	typedef logic signed [VW-1:0] comp_t;
	typedef comp_t vec3_t [3];
	typedef struct packed {
		comp_t c;
		comp_t s;
	} cs_t;
	typedef cs_t cs_set_t [ROTS];

	function automatic logic [31:0] atan_turn(input int unsigned i);
		case (i)
			0: return 32'h20000000;
			1: return 32'h12E4051E;
			2: return 32'h09FB385B;
			3: return 32'h051111D4;
			4: return 32'h028B0D43;
			5: return 32'h0145D7E1;
			6: return 32'h00A2F61E;
			7: return 32'h005170DB;
			8: return 32'h0028BE53;
			9: return 32'h00145F2F;
			10: return 32'h000A2F98;
			11: return 32'h000517CC;
			12: return 32'h00028BE6;
			13: return 32'h000145F3;
			14: return 32'h0000A2FA;
			15: return 32'h0000517D;
			16: return 32'h000028BE;
			17: return 32'h0000145F;
			18: return 32'h00000A30;
			19: return 32'h00000518;
			20: return 32'h0000028C;
			21: return 32'h00000146;
			22: return 32'h000000A3;
			23: return 32'h00000051;
			24: return 32'h00000029;
			25: return 32'h00000014;
			26: return 32'h0000000A;
			27: return 32'h00000005;
			28: return 32'h00000003;
			29: return 32'h00000001;
			30: return 32'h00000001;
			default: return 32'h00000000;
		endcase
	endfunction
endpackage

// File: rtl/losac_if.sv
interface losac_att_if;
	import losac_pkg::*;
	logic valid;
	logic ready;
	logic signed [IN_W-1:0] vehicle_pitch;
	logic signed [IN_W-1:0] vehicle_heading;
	logic signed [IN_W-1:0] vehicle_roll;
	logic signed [IN_W-1:0] camera_pitch;
	logic signed [IN_W-1:0] camera_heading;
	logic signed [IN_W-1:0] camera_roll;
	modport source (output valid, vehicle_pitch, vehicle_heading, vehicle_roll, camera_pitch,
		camera_heading, camera_roll, input ready);
	modport sink (input valid, vehicle_pitch, vehicle_heading, vehicle_roll, camera_pitch,
		camera_heading, camera_roll, output ready);
endinterface

interface losac_sight_if;
	import losac_pkg::*;
	logic valid;
	logic ready;
	logic signed [PITCH_W-1:0] sight_pitch;
	logic signed [HEAD_W-1:0] sight_heading;
	logic signed [PITCH_W-1:0] sight_roll;
	modport source (output valid, sight_pitch, sight_heading, sight_roll, input ready);
	modport sink (input valid, sight_pitch, sight_heading, sight_roll, output ready);
endinterface

// File: rtl/line_of_sight_angle_compose.sv
// Line-of-sight angle composer.
// Input channel "attitude": vehicle pitch/heading/roll and camera mount
// pitch/heading/roll, signed degrees * 2^16. Output channel "sight": combined
// line-of-sight pitch, heading and roll in the same units, saturated to the
// field widths. Both channels transfer when valid and ready are high at a
// rising edge of clk.
// From input transfer to result valid an item passes deg-to-turn,
// sine/cosine CORDIC, six plane rotations, squares, square root, atan2
// CORDIC, turn-to-deg and saturation, in that order.
// Throughput: one item per cycle while sight does not stall; every stage is a register slice.
// The whole pipeline advances together: when sight holds a valid result and
// ready is low, every stage holds and attitude.ready drops in the same
// cycle; no item is lost or repeated. attitude.ready is high whenever sight
// is empty or being taken.
// Reset (arst_n low) clears all valid bits at once; data registers are not
// reset. The block takes items from the first edge after reset release.
module line_of_sight_angle_compose (
	input  logic          clk,
	input  logic          arst_n,
	losac_att_if.sink     attitude,
	losac_sight_if.source sight
);
	import losac_pkg::*;

	localparam logic [ROTS-1:0] TURN_NEG = 6'b011010;
	localparam int DLY = LAT_SQ + LAT_ISQ;
	localparam int MW45 = ZW + 6;
	localparam int DEG_OCT = 45;
	localparam logic signed [VW-1:0] Q30_ONE = {{(VW-31){1'b0}}, 1'b1, 30'd0};

	function automatic logic signed [MW45-1:0] clamp(input logic signed [MW45-1:0] v,
		input int w);
		logic signed [MW45-1:0] hi;
		logic signed [MW45-1:0] lo;
		hi = (MW45'(1) <<< (w - 1)) - MW45'(1);
		lo = -(MW45'(1) <<< (w - 1));
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	logic en;
	logic [LAT_TOTAL-1:0] vld_s;

	assign en = !vld_s[LAT_TOTAL-1] || sight.ready;
	assign attitude.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT_TOTAL-2:0], attitude.valid};
		end
	end

	logic signed [IN_W-1:0] deg_in [ROTS];
	logic [TURN_W-1:0]      turn_w [ROTS];
	cs_set_t                cs_w;

	assign deg_in[0] = attitude.camera_roll;
	assign deg_in[1] = attitude.camera_pitch;
	assign deg_in[2] = attitude.camera_heading;
	assign deg_in[3] = attitude.vehicle_roll;
	assign deg_in[4] = attitude.vehicle_pitch;
	assign deg_in[5] = attitude.vehicle_heading;

	for (genvar k = 0; k < ROTS; k++) begin : g_axis
		losac_turn_gen u_turn (
			.clk  (clk),
			.en   (en),
			.deg  (deg_in[k]),
			.neg  (TURN_NEG[k]),
			.turn (turn_w[k])
		);
		losac_sincos u_sincos (
			.clk  (clk),
			.en   (en),
			.turn (turn_w[k]),
			.cs   (cs_w[k])
		);
	end

	vec3_t fwd_in, side_in, fwd_v, side_v;
	assign fwd_in = '{'0, '0, Q30_ONE};
	assign side_in = '{Q30_ONE, '0, '0};

	losac_vec_turn u_fwd (
		.clk  (clk),
		.en   (en),
		.vin  (fwd_in),
		.cs   (cs_w),
		.vout (fwd_v)
	);

	losac_vec_turn u_side (
		.clk  (clk),
		.en   (en),
		.vin  (side_in),
		.cs   (cs_w),
		.vout (side_v)
	);

	logic signed [PW-1:0] fx2_s1, fz2_s1, sx2_s1, sz2_s1;
	logic [SQ_W-1:0]      nf_s2, ns_s2;
	comp_t                dl_s [DLY][4];

	always_ff @(posedge clk) begin
		if (en) begin
			fx2_s1 <= fwd_v[0] * fwd_v[0];
			fz2_s1 <= fwd_v[2] * fwd_v[2];
			sx2_s1 <= side_v[0] * side_v[0];
			sz2_s1 <= side_v[2] * side_v[2];
			nf_s2 <= SQ_W'(fx2_s1) + SQ_W'(fz2_s1);
			ns_s2 <= SQ_W'(sx2_s1) + SQ_W'(sz2_s1);
			dl_s[0] <= '{fwd_v[0], fwd_v[1], fwd_v[2], side_v[1]};
			for (int j = 1; j < DLY; j++) begin
				dl_s[j] <= dl_s[j-1];
			end
		end
	end

	logic [ROOT_W-1:0] root_f, root_s;

	losac_isqrt u_isqrt_fwd (
		.clk  (clk),
		.en   (en),
		.n    (nf_s2),
		.root (root_f)
	);

	losac_isqrt u_isqrt_side (
		.clk  (clk),
		.en   (en),
		.n    (ns_s2),
		.root (root_s)
	);

	logic signed [ZW-1:0] ang_w [3];

	losac_atan2 u_atan_pitch (
		.clk (clk),
		.en  (en),
		.y   (dl_s[DLY-1][1]),
		.x   (comp_t'({{(VW-ROOT_W){1'b0}}, root_f})),
		.ang (ang_w[0])
	);

	losac_atan2 u_atan_heading (
		.clk (clk),
		.en  (en),
		.y   (dl_s[DLY-1][0]),
		.x   (dl_s[DLY-1][2]),
		.ang (ang_w[1])
	);

	losac_atan2 u_atan_roll (
		.clk (clk),
		.en  (en),
		.y   (dl_s[DLY-1][3]),
		.x   (comp_t'({{(VW-ROOT_W){1'b0}}, root_s})),
		.ang (ang_w[2])
	);

	logic [MW45-1:0]        m45_s1 [3];
	logic                   neg_s1 [3];
	logic [MW45-1:0]        rnd_w [3];
	logic signed [MW45-1:0] deg_w [3];
	logic signed [PITCH_W-1:0] sight_pitch_s2, sight_roll_s2;
	logic signed [HEAD_W-1:0]  sight_heading_s2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rnd_w[k] = (m45_s1[k] + (MW45'(1) << (TURN_SHIFT - 1))) >> TURN_SHIFT;
			deg_w[k] = neg_s1[k] ? -signed'(rnd_w[k]) : signed'(rnd_w[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				m45_s1[k] <= MW45'(ang_w[k][ZW-1] ? -ang_w[k] : ang_w[k]) * MW45'(DEG_OCT);
				neg_s1[k] <= ang_w[k][ZW-1];
			end
			sight_pitch_s2 <= PITCH_W'(clamp(deg_w[0], PITCH_W));
			sight_heading_s2 <= HEAD_W'(clamp(deg_w[1], HEAD_W));
			sight_roll_s2 <= PITCH_W'(clamp(deg_w[2], PITCH_W));
		end
	end

	assign sight.valid = vld_s[LAT_TOTAL-1];
	assign sight.sight_pitch = sight_pitch_s2;
	assign sight.sight_heading = sight_heading_s2;
	assign sight.sight_roll = sight_roll_s2;
endmodule

// File: rtl/losac_turn_gen.sv
module losac_turn_gen (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [losac_pkg::IN_W-1:0]  deg,
	input  logic                               neg,
	output logic [losac_pkg::TURN_W-1:0]       turn
);
	import losac_pkg::*;

	localparam int DIV = 45;
	localparam int ROUND = DIV / 2;
	localparam int MW = IN_W;
	localparam int RCW = 26;
	localparam int PRW = MW + RCW;
	localparam int QW = TURN_W - TURN_SHIFT;
	localparam int BW = 6;
	localparam logic [RCW-1:0] DIV_RECIP = RCW'((64'd1 << 31) / DIV);

	logic [TURN_SHIFT-1:0] frac_tbl [DIV];
	for (genvar g = 0; g < DIV; g++) begin : g_tbl
		assign frac_tbl[g] = TURN_SHIFT'(((g << TURN_SHIFT) + ROUND) / DIV);
	end

	logic [MW-1:0]     mag_s1, mag_s2;
	logic              neg_s1, neg_s2, neg_s3;
	logic [PRW-1:0]    prod_s2;
	logic [QW-1:0]     quo_s3;
	logic [BW-1:0]     rem_s3;
	logic [TURN_W-1:0] turn_s4;

	logic [QW-1:0] quo_est;
	logic [MW-1:0] rem_est;
	assign quo_est = prod_s2[31 +: QW];
	assign rem_est = mag_s2 - MW'(quo_est) * MW'(DIV);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= deg[IN_W-1] ? MW'(-deg) : MW'(deg);
			neg_s1 <= deg[IN_W-1] ^ neg;
			prod_s2 <= PRW'(mag_s1) * PRW'(DIV_RECIP);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			if (rem_est >= MW'(DIV)) begin
				quo_s3 <= quo_est + QW'(1);
				rem_s3 <= BW'(rem_est - MW'(DIV));
			end else begin
				quo_s3 <= quo_est;
				rem_s3 <= BW'(rem_est);
			end
			neg_s3 <= neg_s2;
			turn_s4 <= neg_s3 ? -({quo_s3, frac_tbl[rem_s3]}) : {quo_s3, frac_tbl[rem_s3]};
		end
	end

	assign turn = turn_s4;
endmodule

// File: rtl/losac_sincos.sv
module losac_sincos (
	input  logic                          clk,
	input  logic                          en,
	input  logic [losac_pkg::TURN_W-1:0]  turn,
	output losac_pkg::cs_t                cs
);
	import losac_pkg::*;

	localparam int N = CORDIC_STAGES;

	logic signed [VW-1:0] cx_s [N+1];
	logic signed [VW-1:0] cy_s [N+1];
	logic signed [ZW-1:0] cz_s [N+1];
	logic                 flip_s [N+1];
	cs_t                  cs_s;

	logic signed [ZW-1:0] z_in;
	assign z_in = ZW'(signed'(turn));

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= CORDIC_INV_GAIN;
			cy_s[0] <= '0;
			if (z_in > QUARTER_TURN) begin
				cz_s[0] <= z_in - HALF_TURN;
				flip_s[0] <= 1'b1;
			end else if (z_in < -QUARTER_TURN) begin
				cz_s[0] <= z_in + HALF_TURN;
				flip_s[0] <= 1'b1;
			end else begin
				cz_s[0] <= z_in;
				flip_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam logic signed [ZW-1:0] AT = ZW'(atan_turn(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (cz_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - AT;
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + AT;
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s.c <= flip_s[N] ? -cx_s[N] : cx_s[N];
			cs_s.s <= flip_s[N] ? -cy_s[N] : cy_s[N];
		end
	end

	assign cs = cs_s;
endmodule

// File: rtl/losac_vec_turn.sv
module losac_vec_turn (
	input  logic                 clk,
	input  logic                 en,
	input  losac_pkg::vec3_t     vin,
	input  losac_pkg::cs_set_t   cs,
	output losac_pkg::vec3_t     vout
);
	import losac_pkg::*;

	localparam logic signed [PW-1:0] RND = {{(PW-30){1'b0}}, 1'b1, 29'd0};

	vec3_t                v_s [2*ROTS+1];
	cs_set_t              cs_s [2*ROTS-1];
	logic signed [PW-1:0] cp_s [ROTS];
	logic signed [PW-1:0] sq_s [ROTS];
	logic signed [PW-1:0] sp_s [ROTS];
	logic signed [PW-1:0] cq_s [ROTS];

	assign v_s[0] = vin;
	assign cs_s[0] = cs;

	for (genvar k = 0; k < ROTS; k++) begin : g_rot
		localparam int P = k % 3;
		localparam int Q = (k + 1) % 3;
		localparam int R = (k + 2) % 3;

		always_ff @(posedge clk) begin
			if (en) begin
				cp_s[k] <= cs_s[2*k][k].c * v_s[2*k][P];
				sq_s[k] <= cs_s[2*k][k].s * v_s[2*k][Q];
				sp_s[k] <= cs_s[2*k][k].s * v_s[2*k][P];
				cq_s[k] <= cs_s[2*k][k].c * v_s[2*k][Q];
				v_s[2*k+1] <= v_s[2*k];
				v_s[2*k+2][P] <= VW'((cp_s[k] - sq_s[k] + RND) >>> Q30_SH);
				v_s[2*k+2][Q] <= VW'((sp_s[k] + cq_s[k] + RND) >>> Q30_SH);
				v_s[2*k+2][R] <= v_s[2*k+1][R];
			end
		end

		if (k < ROTS - 1) begin : g_cs
			always_ff @(posedge clk) begin
				if (en) begin
					cs_s[2*k+1] <= cs_s[2*k];
					cs_s[2*k+2] <= cs_s[2*k+1];
				end
			end
		end
	end

	assign vout = v_s[2*ROTS];
endmodule

// File: rtl/losac_isqrt.sv
module losac_isqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [losac_pkg::SQ_W-1:0]    n,
	output logic [losac_pkg::ROOT_W-1:0]  root
);
	import losac_pkg::*;

	logic [SQ_W-1:0] rem_s [ROOT_W+1];
	logic [SQ_W-1:0] res_s [ROOT_W+1];

	assign rem_s[0] = n;
	assign res_s[0] = '0;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
		logic [SQ_W-1:0] trial;
		assign trial = res_s[i] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[i] >= trial) begin
					rem_s[i+1] <= rem_s[i] - trial;
					res_s[i+1] <= (res_s[i] >> 1) + BIT;
				end else begin
					rem_s[i+1] <= rem_s[i];
					res_s[i+1] <= res_s[i] >> 1;
				end
			end
		end
	end

	assign root = res_s[ROOT_W][ROOT_W-1:0];
endmodule

// File: rtl/losac_atan2.sv
module losac_atan2 (
	input  logic                              clk,
	input  logic                              en,
	input  losac_pkg::comp_t                  y,
	input  losac_pkg::comp_t                  x,
	output logic signed [losac_pkg::ZW-1:0]   ang
);
	import losac_pkg::*;

	localparam int N = CORDIC_STAGES;

	logic signed [AW-1:0] ax_s [N+1];
	logic signed [AW-1:0] ay_s [N+1];
	logic signed [ZW-1:0] az_s [N+1];
	logic                 zero_s [N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x == '0) && (y == '0);
			if (x < 0) begin
				ax_s[0] <= -AW'(x);
				ay_s[0] <= -AW'(y);
				az_s[0] <= (y >= 0) ? HALF_TURN : -HALF_TURN;
			end else begin
				ax_s[0] <= AW'(x);
				ay_s[0] <= AW'(y);
				az_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam logic signed [ZW-1:0] AT = ZW'(atan_turn(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (ay_s[i] > 0) begin
					ax_s[i+1] <= ax_s[i] + (ay_s[i] >>> i);
					ay_s[i+1] <= ay_s[i] - (ax_s[i] >>> i);
					az_s[i+1] <= az_s[i] + AT;
				end else begin
					ax_s[i+1] <= ax_s[i] - (ay_s[i] >>> i);
					ay_s[i+1] <= ay_s[i] + (ax_s[i] >>> i);
					az_s[i+1] <= az_s[i] - AT;
				end
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	assign ang = zero_s[N] ? '0 : az_s[N];
endmodule

// File: rtl/losac_checker.sv
`include "line_of_sight_angle_compose_assert.svh"
module losac_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                att_valid,
	input logic                                att_ready,
	input logic                                sight_valid,
	input logic                                sight_ready,
	input logic signed [losac_pkg::PITCH_W-1:0] sight_pitch,
	input logic signed [losac_pkg::HEAD_W-1:0]  sight_heading,
	input logic signed [losac_pkg::PITCH_W-1:0] sight_roll
);
	import losac_pkg::*;

	logic att_xfer;
	logic out_stall;
	logic [2*PITCH_W+HEAD_W-1:0] out_word;
	assign att_xfer = att_valid && att_ready;
	assign out_stall = sight_valid && !sight_ready;
	assign out_word = {sight_pitch, sight_heading, sight_roll};

	`LOSAC_ASSERT(a_ready_tracks_stall, clk, arst_n, att_ready == (!sight_valid || sight_ready))
	`LOSAC_ASSERT_ALL(a_empty_in_reset, clk, !arst_n |-> !sight_valid && att_ready)
	`LOSAC_ASSERT(a_stall_holds, clk, arst_n, out_stall |=> sight_valid && $stable(out_word))
	`LOSAC_ASSERT(a_no_take_in_stall, clk, arst_n, out_stall |-> !att_xfer)
endmodule

bind line_of_sight_angle_compose losac_checker u_losac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.att_valid     (attitude.valid),
	.att_ready     (attitude.ready),
	.sight_valid   (sight.valid),
	.sight_ready   (sight.ready),
	.sight_pitch   (sight.sight_pitch),
	.sight_heading (sight.sight_heading),
	.sight_roll    (sight.sight_roll)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import losac_pkg::*;

	localparam int N_RANDOM = 1400;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint Q_ONE = 64'sd1 << 30;
	localparam longint Q_HALF = 64'sd1 << 29;
	localparam longint HALF_T = 64'sd1 << 31;
	localparam longint QUARTER_T = 64'sd1 << 30;
	localparam longint INV_GAIN = 64'sh26DD3B6A;
	localparam int DEG = 65536;

	localparam longint ARC_STEP [32] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h005170DB, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
		64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
		64'h00000001, 64'h00000000
	};

	typedef struct packed {
		logic signed [IN_W-1:0] vp;
		logic signed [IN_W-1:0] vh;
		logic signed [IN_W-1:0] vr;
		logic signed [IN_W-1:0] cp;
		logic signed [IN_W-1:0] ch;
		logic signed [IN_W-1:0] cr;
	} attitude_t;

	typedef struct packed {
		logic signed [PITCH_W-1:0] pitch;
		logic signed [HEAD_W-1:0] heading;
		logic signed [PITCH_W-1:0] roll;
	} sight_t;

	typedef struct packed {
		attitude_t att;
		logic known;
		sight_t sight;
	} dir_row_t;

	localparam int N_DIR = 20;
	localparam sight_t ZERO_SIGHT = '0;
	localparam logic signed [IN_W-1:0] MAXV = 25'sh0FFFFFF;
	localparam logic signed [IN_W-1:0] MINV = -25'sh1000000;
	localparam logic signed [IN_W-1:0] D180 = 180 * DEG;
	localparam logic signed [IN_W-1:0] D90 = 90 * DEG;
	localparam dir_row_t DIR_TAB [N_DIR] = '{
		'{'{0, 0, 0, 0, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{MAXV, 0, 0, 0, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{MINV, 0, 0, 0, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{0, MAXV, 0, 0, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{0, MINV, 0, 0, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{0, 0, MAXV, 0, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{0, 0, MINV, 0, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{0, 0, 0, MAXV, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{0, 0, 0, MINV, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{0, 0, 0, 0, MAXV, 0}, 1'b0, ZERO_SIGHT},
		'{'{0, 0, 0, 0, MINV, 0}, 1'b0, ZERO_SIGHT},
		'{'{0, 0, 0, 0, 0, MAXV}, 1'b0, ZERO_SIGHT},
		'{'{0, 0, 0, 0, 0, MINV}, 1'b0, ZERO_SIGHT},
		'{'{0, D180, 0, 0, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{0, -D180, 0, 0, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{D90, 0, 0, 0, 0, 0}, 1'b0, ZERO_SIGHT},
		'{'{-D90, 0, 0, 0, D90, 0}, 1'b0, ZERO_SIGHT},
		'{'{D90, 0, D90, D90, 0, D90}, 1'b0, ZERO_SIGHT},
		'{'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 1'b0, ZERO_SIGHT},
		'{'{MINV, MINV, MINV, MINV, MINV, MINV}, 1'b0, ZERO_SIGHT}
	};

	logic clk;
	logic arst_n;
	losac_att_if att ();
	losac_sight_if sgt ();

	line_of_sight_angle_compose u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.attitude(att),
		.sight   (sgt)
	);

	sight_t pending_sight [$];
	int mismatches = 0;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	function automatic logic [31:0] deg_to_turn(input logic signed [IN_W-1:0] d);
		longint dd;
		longint unsigned m;
		longint unsigned q;
		logic [31:0] t;
		dd = d;
		m = (dd < 0) ? longint'(-dd) : longint'(dd);
		q = ((m << TURN_SHIFT) + 64'd22) / 64'd45;
		t = q[31:0];
		return (dd < 0) ? 32'(0 - t) : t;
	endfunction

	function automatic longint turn_to_deg(input longint b);
		longint unsigned m;
		longint unsigned r;
		m = ((b < 0) ? longint'(-b) : longint'(b)) * 64'd45;
		r = (m + (64'd1 << (TURN_SHIFT - 1))) >> TURN_SHIFT;
		return (b < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clamp(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		lo = -(64'sd1 <<< (bits - 1));
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic void sin_cos(input logic [31:0] a, output longint c, output longint s);
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		bit flip;
		z = longint'({32'b0, a});
		x = INV_GAIN;
		y = 0;
		flip = 0;
		if (z >= HALF_T) z -= 2 * HALF_T;
		if (z > QUARTER_T) begin
			z -= HALF_T;
			flip = 1;
		end else if (z < -QUARTER_T) begin
			z += HALF_T;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ARC_STEP[i];
			end else begin
				x += dx;
				y -= dy;
				z += ARC_STEP[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint arc_tan2(input longint yi, input longint xi);
		longint x;
		longint y;
		longint z;
		longint base;
		longint dx;
		longint dy;
		x = xi;
		y = yi;
		z = 0;
		base = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			base = (y >= 0) ? HALF_T : -HALF_T;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += ARC_STEP[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ARC_STEP[i];
			end
		end
		return base + z;
	endfunction

	function automatic longint int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		longint unsigned rem;
		res = 0;
		rem = n;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic void plane_turn(inout longint p, inout longint q,
		input longint c, input longint s);
		longint np;
		longint nq;
		np = (c * p - s * q + Q_HALF) >>> 30;
		nq = (s * p + c * q + Q_HALF) >>> 30;
		p = np;
		q = nq;
	endfunction

	function automatic void spin(inout longint v0, inout longint v1, inout longint v2,
		input longint cc [6], input longint ss [6]);
		plane_turn(v0, v1, cc[0], ss[0]);
		plane_turn(v1, v2, cc[1], ss[1]);
		plane_turn(v2, v0, cc[2], ss[2]);
		plane_turn(v0, v1, cc[3], ss[3]);
		plane_turn(v1, v2, cc[4], ss[4]);
		plane_turn(v2, v0, cc[5], ss[5]);
	endfunction

	function automatic longint elev(input longint v0, input longint v1, input longint v2);
		longint unsigned sq;
		sq = longint'(v0 * v0) + longint'(v2 * v2);
		return arc_tan2(v1, int_sqrt(sq));
	endfunction

	function automatic sight_t compose_sight(input attitude_t a);
		logic [31:0] ang [6];
		longint cc [6];
		longint ss [6];
		longint f0, f1, f2, s0, s1, s2;
		sight_t r;
		ang[0] = deg_to_turn(a.cr);
		ang[1] = 32'(0 - deg_to_turn(a.cp));
		ang[2] = deg_to_turn(a.ch);
		ang[3] = 32'(0 - deg_to_turn(a.vr));
		ang[4] = 32'(0 - deg_to_turn(a.vp));
		ang[5] = deg_to_turn(a.vh);
		for (int k = 0; k < 6; k++) sin_cos(ang[k], cc[k], ss[k]);
		f0 = 0;
		f1 = 0;
		f2 = Q_ONE;
		s0 = Q_ONE;
		s1 = 0;
		s2 = 0;
		spin(f0, f1, f2, cc, ss);
		spin(s0, s1, s2, cc, ss);
		r.pitch = PITCH_W'(clamp(turn_to_deg(elev(f0, f1, f2)), PITCH_W));
		r.heading = HEAD_W'(clamp(turn_to_deg(arc_tan2(f0, f2)), HEAD_W));
		r.roll = PITCH_W'(clamp(turn_to_deg(elev(s0, s1, s2)), PITCH_W));
		return r;
	endfunction

	function automatic logic signed [IN_W-1:0] rand_angle();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) return IN_W'($urandom_range(2 * 11796480) - 11796480);
		if (sel < 90) return IN_W'($urandom);
		return IN_W'(($urandom_range(8) - 4) * D90 + $urandom_range(8) - 4);
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		sgt.ready = 0;
		forever begin
			@(negedge clk);
			sgt.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		sight_t want;
		if (arst_n && sgt.valid && sgt.ready) begin
			if (pending_sight.size() == 0) begin
				report("unexpected transfer", sgt.sight_pitch, 0);
			end else begin
				want = pending_sight.pop_front();
				if (sgt.sight_pitch !== want.pitch)
					report("sight_pitch", sgt.sight_pitch, want.pitch);
				if (sgt.sight_heading !== want.heading)
					report("sight_heading", sgt.sight_heading, want.heading);
				if (sgt.sight_roll !== want.roll)
					report("sight_roll", sgt.sight_roll, want.roll);
			end
		end
	end

	initial begin
		attitude_t a;
		sight_t want;
		int total;
		int phase;
		total = N_DIR + N_RANDOM;
		arst_n = 0;
		att.valid = 0;
		{att.vehicle_pitch, att.vehicle_heading, att.vehicle_roll,
			att.camera_pitch, att.camera_heading, att.camera_roll} = '0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		for (int i = 0; i < total; i++) begin
			phase = (i * 4) / total;
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 62; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 62; end
				default: begin idle_pct = 24; stall_pct = 24; end
			endcase
			if (i < N_DIR) begin
				a = DIR_TAB[i].att;
				want = DIR_TAB[i].known ? DIR_TAB[i].sight : compose_sight(a);
			end else begin
				a = {rand_angle(), rand_angle(), rand_angle(),
					rand_angle(), rand_angle(), rand_angle()};
				want = compose_sight(a);
			end
			while ($urandom_range(99) < idle_pct) begin
				@(negedge clk);
				att.valid <= 0;
			end
			@(negedge clk);
			att.valid <= 1;
			att.vehicle_pitch <= a.vp;
			att.vehicle_heading <= a.vh;
			att.vehicle_roll <= a.vr;
			att.camera_pitch <= a.cp;
			att.camera_heading <= a.ch;
			att.camera_roll <= a.cr;
			do @(posedge clk); while (!att.ready);
			pending_sight.push_back(want);
		end
		@(negedge clk);
		att.valid <= 0;
		while (pending_sight.size() != 0) @(posedge clk);
		repeat (LAT_TOTAL + 20) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
